### rtl/qfd_pkg.sv
// shared constants, types and status codes of the fixed-point divider
package qfd_pkg;

  localparam int DATA_W         = 32;
  localparam int FRAC_BITS      = 16;
  localparam int BITS_PER_STAGE = 2;
  // at least one leading zero above the 32-bit range so overflow is always visible
  localparam int NUM_STAGES     = (DATA_W + FRAC_BITS + BITS_PER_STAGE) / BITS_PER_STAGE;
  localparam int WORK_W         = NUM_STAGES * BITS_PER_STAGE;
  localparam int REM_W          = DATA_W + 1;
  localparam int STATUS_W       = 2;

  typedef enum logic [STATUS_W-1:0] {
    DIV_OK       = 2'd0,
    DIV_ZERO     = 2'd1,
    DIV_OVERFLOW = 2'd2
  } div_status_t;

  // one request in flight through the divide pipeline
  typedef struct packed {
    logic              valid;
    logic              dz;
    logic              neg;
    logic [DATA_W-1:0] dmag;
    logic [REM_W-1:0]  rem;
    logic [WORK_W-1:0] work;
  } div_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] quotient;
    div_status_t       status;
  } res_t;

endpackage

### rtl/qfd_in_if.sv
// request channel: dividend and divisor with valid/ready
interface qfd_in_if;
  logic                       valid;
  logic                       ready;
  logic [qfd_pkg::DATA_W-1:0] dividend_q16;
  logic [qfd_pkg::DATA_W-1:0] divisor_q16;

  modport source (output valid, output dividend_q16, output divisor_q16, input ready);
  modport sink   (input valid, input dividend_q16, input divisor_q16, output ready);
endinterface

### rtl/qfd_out_if.sv
// result channel: quotient and status with valid/ready
interface qfd_out_if;
  logic                         valid;
  logic                         ready;
  logic [qfd_pkg::DATA_W-1:0]   quotient_q16;
  logic [qfd_pkg::STATUS_W-1:0] div_status;

  modport source (output valid, output quotient_q16, output div_status, input ready);
  modport sink   (input valid, input quotient_q16, input div_status, output ready);
endinterface

### rtl/qfd_front.sv
// input stage: operand magnitudes, sign and zero-divisor detection
module qfd_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       valid,
  input  logic [qfd_pkg::DATA_W-1:0] dividend,
  input  logic [qfd_pkg::DATA_W-1:0] divisor,
  output qfd_pkg::div_t              q
);
  import qfd_pkg::*;

  logic [DATA_W-1:0] nmag;
  logic [DATA_W-1:0] dmag;

  // unsigned magnitude, the most negative value maps to 2^31
  assign nmag = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
  assign dmag = divisor[DATA_W-1]  ? (~divisor + DATA_W'(1))  : divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.dz   <= (divisor == '0);
      q.neg  <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      q.dmag <= dmag;
      q.rem  <= '0;
      q.work <= WORK_W'(nmag) << FRAC_BITS;
    end
  end

endmodule

### rtl/qfd_div_stage.sv
// one pipeline stage of restoring division, BITS_PER_STAGE (two) quotient bits per stage
module qfd_div_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  qfd_pkg::div_t d,
  output qfd_pkg::div_t q
);
  import qfd_pkg::*;

  logic [REM_W-1:0]  rem_next;
  logic [WORK_W-1:0] work_next;
  logic [REM_W-1:0]  trial;

  always_comb begin
    rem_next  = d.rem;
    work_next = d.work;
    trial     = '0;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      // bring down the next dividend bit, shift quotient in from the bottom
      trial     = {rem_next[REM_W-2:0], work_next[WORK_W-1]};
      work_next = {work_next[WORK_W-2:0], 1'b0};
      if (trial >= {1'b0, d.dmag}) begin
        trial        = trial - {1'b0, d.dmag};
        work_next[0] = 1'b1;
      end
      rem_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.dz   <= d.dz;
      q.neg  <= d.neg;
      q.dmag <= d.dmag;
      q.rem  <= rem_next;
      q.work <= work_next;
    end
  end

endmodule

### rtl/qfd_back.sv
// output stage: sign fix-up, range check and status
module qfd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  qfd_pkg::div_t d,
  output qfd_pkg::res_t q
);
  import qfd_pkg::*;

  logic              qzero;
  logic              qneg;
  logic              hi_set;
  logic [DATA_W-1:0] low;
  logic              ovf;
  logic [DATA_W-1:0] quotient_next;
  div_status_t       status_next;

  assign qzero  = (d.work == '0);
  assign qneg   = d.neg & ~qzero;
  assign hi_set = |d.work[WORK_W-1:DATA_W];
  assign low    = d.work[DATA_W-1:0];
  // negative results may reach 2^31, positive ones stop one short
  assign ovf    = hi_set | (qneg ? (low > {1'b1, {(DATA_W-1){1'b0}}}) : low[DATA_W-1]);

  always_comb begin
    if (d.dz) begin
      status_next   = DIV_ZERO;
      quotient_next = '0;
    end else if (ovf) begin
      status_next   = DIV_OVERFLOW;
      quotient_next = '0;
    end else begin
      status_next   = DIV_OK;
      quotient_next = qneg ? (~low + DATA_W'(1)) : low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.quotient <= quotient_next;
      q.status   <= status_next;
    end
  end

endmodule

### rtl/q16_fixed_point_divider.sv
// top level of the pipelined signed Q16.16 divider
// path: front register, NUM_STAGES divide stages, then the output register
// throughput: one request per cycle while the result side takes every result
// the divide chain retires two quotient bits per stage, so its depth sets the latency
// a held result freezes the whole pipeline; nothing is dropped or repeated
// reset (synchronous, active high) clears every stage's valid bit; no other state
module q16_fixed_point_divider (
  input  logic       clk,
  input  logic       rst,
  qfd_in_if.sink     req,
  qfd_out_if.source  rsp
);
  import qfd_pkg::*;

  // pipe[0] is the front register, pipe[NUM_STAGES] feeds the output stage
  div_t pipe [NUM_STAGES+1];
  res_t res;
  logic en;

  // advance when the output register is empty or being drained
  assign en        = ~res.valid | rsp.ready;
  assign req.ready = en;

  // magnitudes, sign of the result and zero-divisor flag
  qfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid    (req.valid),
    .dividend (req.dividend_q16),
    .divisor  (req.divisor_q16),
    .q        (pipe[0])
  );

  // restoring division: remainder and dividend/quotient word shift left together
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    qfd_div_stage u_stage (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (pipe[s]),
      .q   (pipe[s+1])
    );
  end

  // sign restore, 32-bit range check and status encoding
  qfd_back u_back (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   (pipe[NUM_STAGES]),
    .q   (res)
  );

  assign rsp.valid        = res.valid;
  assign rsp.quotient_q16 = res.quotient;
  assign rsp.div_status   = res.status;

endmodule

### tb/qfd_checker.sv
// quotient predictor and scoreboard that watches both divider channels
`timescale 1ns / 100ps

module qfd_checker (
  input  logic clk,
  input  logic rst,
  qfd_in_if    req,
  qfd_out_if   rsp,
  output int   fail_count,
  output int   pending
);
  import qfd_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] quotient;
    div_status_t       status;
  } quot_rec_t;

  quot_rec_t quot_q[$];
  int        fails = 0;

  // signed Q16.16 divide, truncated toward zero, on magnitudes
  function automatic quot_rec_t predict_quotient(logic [DATA_W-1:0] dvd,
                                                 logic [DATA_W-1:0] dvs);
    logic        dvd_neg;
    logic        dvs_neg;
    logic        q_neg;
    logic [63:0] dvd_mag;
    logic [63:0] dvs_mag;
    logic [63:0] q_mag;
    quot_rec_t   r;
    dvd_neg = dvd[DATA_W-1];
    dvs_neg = dvs[DATA_W-1];
    dvd_mag = dvd_neg ? 64'h1_0000_0000 - {32'b0, dvd} : {32'b0, dvd};
    dvs_mag = dvs_neg ? 64'h1_0000_0000 - {32'b0, dvs} : {32'b0, dvs};
    r.quotient = '0;
    if (dvs_mag == 64'd0) begin
      r.status = DIV_ZERO;
      return r;
    end
    q_mag = (dvd_mag << FRAC_BITS) / dvs_mag;
    q_neg = (dvd_neg != dvs_neg) && (q_mag != 64'd0);
    if (q_neg ? (q_mag > 64'h8000_0000) : (q_mag > 64'h7FFF_FFFF)) begin
      r.status = DIV_OVERFLOW;
      return r;
    end
    r.quotient = q_neg ? 32'(64'd0 - q_mag) : q_mag[31:0];
    r.status   = DIV_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    quot_rec_t want;
    if (!rst) begin
      if (req.valid && req.ready)
        quot_q.push_back(predict_quotient(req.dividend_q16, req.divisor_q16));
      if (rsp.valid && rsp.ready) begin
        if (quot_q.size() == 0) begin
          fails = fails + 1;
          $display("%0t: result with nothing pending: quotient %h status %0d",
                   $time, rsp.quotient_q16, rsp.div_status);
        end else begin
          want = quot_q.pop_front();
          if (rsp.quotient_q16 !== want.quotient) begin
            fails = fails + 1;
            $display("%0t: quotient mismatch: expected %h actual %h",
                     $time, want.quotient, rsp.quotient_q16);
          end
          if (rsp.div_status !== want.status) begin
            fails = fails + 1;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, rsp.div_status);
          end
        end
      end
    end
    pending    <= quot_q.size();
    fail_count <= fails;
  end

endmodule

### tb/tb_q16_fixed_point_divider.sv
// stimulus, clock, reset and verdict for the pipelined Q16.16 divider
`timescale 1ns / 100ps

module tb_q16_fixed_point_divider;
  import qfd_pkg::*;

  localparam int NUM_RANDOM   = 1000;
  localparam int CYCLE_LIMIT  = 200000;
  // pipeline depth plus margin for the drain at the end
  localparam int DRAIN_CYCLES = NUM_STAGES + 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 650;

  localparam logic [31:0] Q_MIN     = 32'h8000_0000;
  localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_ONE     = 32'h0001_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycles        = 0;
  int   requests_sent = 0;

  qfd_in_if  req ();
  qfd_out_if rsp ();

  q16_fixed_point_divider dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  qfd_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  // hard stop in case the pipeline hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // both sides run without gaps for a stretch in the middle of the random part
  function automatic logic calm_stretch();
    return requests_sent >= 250 && requests_sent < 450;
  endfunction

  // one request: optional random gap, then hold valid until the handshake
  task automatic send_request(logic [31:0] dvd, logic [31:0] dvs);
    while (!calm_stretch() && $urandom_range(99) < 17) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.dividend_q16 <= dvd;
    req.divisor_q16  <= dvs;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    requests_sent = requests_sent + 1;
  endtask

  // operand mix: full-range patterns, scaled magnitudes, extremes and zero
  function automatic logic [31:0] rand_operand(int zero_pct);
    int          pick;
    logic [31:0] v;
    pick = $urandom_range(99);
    if (pick < zero_pct) begin
      v = 32'd0;
    end else if (pick < 40) begin
      v = $urandom;
    end else if (pick < 90) begin
      // shifted magnitude keeps the quotient near the 32-bit boundary often
      v = $urandom >> $urandom_range(31);
      if ($urandom_range(1)) v = 32'd0 - v;
    end else begin
      case ($urandom_range(5))
        0: v = Q_MIN;
        1: v = Q_MAX;
        2: v = Q_ONE;
        3: v = Q_NEG_ONE;
        4: v = 32'd1;
        default: v = 32'hFFFF_FFFF;
      endcase
    end
    return v;
  endfunction

  // receiver: random stalls, a calm stretch, and one long hold-off that
  // backs the pipeline up until the request side stalls
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (!hold_done && requests_sent >= HOLD_AT) begin
        rsp.ready <= 1'b0;
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1;
      end else begin
        rsp.ready <= calm_stretch() || ($urandom_range(99) >= 17);
      end
    end
  end

  initial begin
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.dividend_q16 <= '0;
    req.divisor_q16  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: unit values and full-range extremes
    send_request(Q_ONE, Q_ONE);
    send_request(Q_MIN, Q_ONE);          // most negative quotient still fits
    send_request(Q_MAX, Q_ONE);
    send_request(Q_MAX, Q_NEG_ONE);
    send_request(Q_MIN, Q_MIN);
    send_request(32'd0, Q_MIN);
    // zero divisor with several dividends
    send_request(32'd0, 32'd0);
    send_request(Q_MIN, 32'd0);
    send_request(Q_MAX, 32'd0);
    // positive quotients out of range, and the negative bound that still fits
    send_request(Q_MIN, Q_NEG_ONE);
    send_request(Q_MAX, 32'd1);
    send_request(Q_MIN, 32'hFFFF_FFFF);
    send_request(32'h4000_0000, 32'h0000_8000);  // exactly 2^31, overflows
    send_request(32'hC000_0000, 32'h0000_8000);  // exactly -2^31, fits
    // truncation toward zero for every sign pairing
    send_request(32'h0007_0000, 32'h0003_0000);
    send_request(32'hFFF9_0000, 32'h0003_0000);
    send_request(32'h0007_0000, 32'hFFFD_0000);
    send_request(32'hFFF9_0000, 32'hFFFD_0000);
    // tiny quotients that truncate to zero, both signs, then a quotient of exactly -1 and one just above -1
    send_request(32'd1, Q_MAX);
    send_request(32'hFFFF_FFFF, Q_MAX);
    send_request(32'd1, 32'hFFFF_FFFF);
    send_request(Q_MAX, Q_MIN);

    // random part; the sign bit and every other bit flip on both operands
    requests_sent = 0;
    for (int i = 0; i < NUM_RANDOM; i++)
      send_request(rand_operand(2), rand_operand(4));
    req.valid <= 1'b0;

    // let the last request land in the scoreboard before looking at it
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
rtl/qfd_pkg.sv
rtl/qfd_in_if.sv
rtl/qfd_out_if.sv
rtl/qfd_front.sv
rtl/qfd_div_stage.sv
rtl/qfd_back.sv
rtl/q16_fixed_point_divider.sv
tb/qfd_checker.sv
tb/tb_q16_fixed_point_divider.sv
